### rtl/quaternion_multiply_normalize_top_defines.svh
// Assertion macros shared by the checker of the quaternion product block.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_TOP_DEFINES_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define QMN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define QMN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/qmn_pkg.sv
// Shared constants of the normalized quaternion product block.
package qmn_pkg;

  // Default fixed-point format of all components.
  localparam int unsigned FRAC_BITS_DEF      = 14;
  localparam int unsigned COMPONENT_BITS_DEF = 16;

  // Number of quaternion components and their lane order.
  localparam int unsigned LANES  = 4;
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;
  localparam int unsigned LANE_Z = 3;

  // Register stages in front of the square root cells.
  localparam int unsigned FRONT_STAGES = 4;

endpackage

### rtl/qmn_front.sv
// Front cells: Hamilton product, floor shift, absolute values and sum of squares.
module qmn_front #(
  parameter int unsigned FRAC_BITS      = qmn_pkg::FRAC_BITS_DEF,
  parameter int unsigned COMPONENT_BITS = qmn_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [qmn_pkg::FRONT_STAGES-1:0]            en_i,
  input  logic                                        valid_i,
  output logic [qmn_pkg::FRONT_STAGES-1:0]            valid_o,
  input  logic signed [COMPONENT_BITS-1:0]            a_i [qmn_pkg::LANES],
  input  logic signed [COMPONENT_BITS-1:0]            b_i [qmn_pkg::LANES],
  output logic [2*(2*COMPONENT_BITS+2-FRAC_BITS)+1:0] sq_o,
  output logic                                        neg_o [qmn_pkg::LANES],
  output logic [2*COMPONENT_BITS+1-FRAC_BITS:0]       abs_o [qmn_pkg::LANES]
);
  import qmn_pkg::*;

  localparam int unsigned CB  = COMPONENT_BITS;
  localparam int unsigned SW  = 2 * CB + 2;
  localparam int unsigned PW  = SW - FRAC_BITS;
  localparam int unsigned SQW = 2 * PW + 2;

  logic [FRONT_STAGES-1:0]   valid_q;
  logic signed [2*CB-1:0]    prod_q [LANES][LANES];
  logic signed [SW-1:0]      sum    [LANES];
  logic signed [PW-1:0]      p      [LANES];
  logic                      neg2_q [LANES];
  logic [PW-1:0]             abs2_q [LANES];
  logic                      neg3_q [LANES];
  logic [PW-1:0]             abs3_q [LANES];
  logic [2*PW-1:0]           sqr3_q [LANES];
  logic                      neg4_q [LANES];
  logic [PW-1:0]             abs4_q [LANES];
  logic [SQW-1:0]            sq4_q;

  // Valid bits of the four front cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) valid_q[0] <= valid_i;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en_i[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // Cell one: all sixteen component products.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          prod_q[i][j] <= a_i[i] * b_i[j];
        end
      end
    end
  end

  // Exact component sums, then a floor shift by the fraction width.
  always_comb begin
    sum[LANE_W] = SW'(prod_q[LANE_W][LANE_W]) - SW'(prod_q[LANE_X][LANE_X])
                - SW'(prod_q[LANE_Y][LANE_Y]) - SW'(prod_q[LANE_Z][LANE_Z]);
    sum[LANE_X] = SW'(prod_q[LANE_W][LANE_X]) + SW'(prod_q[LANE_X][LANE_W])
                + SW'(prod_q[LANE_Y][LANE_Z]) - SW'(prod_q[LANE_Z][LANE_Y]);
    sum[LANE_Y] = SW'(prod_q[LANE_W][LANE_Y]) + SW'(prod_q[LANE_Y][LANE_W])
                + SW'(prod_q[LANE_Z][LANE_X]) - SW'(prod_q[LANE_X][LANE_Z]);
    sum[LANE_Z] = SW'(prod_q[LANE_W][LANE_Z]) + SW'(prod_q[LANE_Z][LANE_W])
                + SW'(prod_q[LANE_X][LANE_Y]) - SW'(prod_q[LANE_Y][LANE_X]);
    for (int i = 0; i < LANES; i++) begin
      p[i] = sum[i][SW-1:FRAC_BITS];
    end
  end

  // Cell two: sign and magnitude of each shifted component.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < LANES; i++) begin
        neg2_q[i] <= p[i][PW-1];
        abs2_q[i] <= p[i][PW-1] ? PW'(-p[i]) : PW'(p[i]);
      end
    end
  end

  // Cell three: squares of the magnitudes.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < LANES; i++) begin
        neg3_q[i] <= neg2_q[i];
        abs3_q[i] <= abs2_q[i];
        sqr3_q[i] <= abs2_q[i] * abs2_q[i];
      end
    end
  end

  // Cell four: sum of the squares.
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      neg4_q <= neg3_q;
      abs4_q <= abs3_q;
      sq4_q  <= SQW'(sqr3_q[LANE_W]) + SQW'(sqr3_q[LANE_X])
              + SQW'(sqr3_q[LANE_Y]) + SQW'(sqr3_q[LANE_Z]);
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq4_q;
  assign neg_o   = neg4_q;
  assign abs_o   = abs4_q;

endmodule

### rtl/qmn_sqrt_cell.sv
// One square root cell: settles one bit of the root per item.
module qmn_sqrt_cell #(
  parameter int unsigned RW = 21,
  parameter int unsigned PW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  output logic            valid_o,
  input  logic [2*RW-1:0] n_i,
  input  logic [RW+1:0]   r_i,
  input  logic [RW-1:0]   q_i,
  input  logic            neg_i [qmn_pkg::LANES],
  input  logic [PW-1:0]   abs_i [qmn_pkg::LANES],
  output logic [2*RW-1:0] n_o,
  output logic [RW+1:0]   r_o,
  output logic [RW-1:0]   q_o,
  output logic            neg_o [qmn_pkg::LANES],
  output logic [PW-1:0]   abs_o [qmn_pkg::LANES]
);
  import qmn_pkg::*;

  logic            valid_q;
  logic [2*RW-1:0] n_q;
  logic [RW+1:0]   r_q;
  logic [RW-1:0]   q_q;
  logic            neg_q [LANES];
  logic [PW-1:0]   abs_q [LANES];
  logic [RW+1:0]   rem;
  logic [RW+1:0]   trial;
  logic            ge;

  // Bring down the next bit pair and try to set the next root bit.
  always_comb begin
    rem   = {r_i[RW-1:0], n_i[2*RW-1 -: 2]};
    trial = {q_i, 2'b01};
    ge    = (rem >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= {n_i[2*RW-3:0], 2'b00};
      r_q   <= ge ? (rem - trial) : rem;
      q_q   <= {q_i[RW-2:0], ge};
      neg_q <= neg_i;
      abs_q <= abs_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign r_o     = r_q;
  assign q_o     = q_q;
  assign neg_o   = neg_q;
  assign abs_o   = abs_q;

endmodule

### rtl/qmn_div_cell.sv
// One divide cell: settles one quotient bit of all four components per item.
module qmn_div_cell #(
  parameter int unsigned RW = 21,
  parameter int unsigned FB = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  output logic          valid_o,
  input  logic [RW-1:0] m_i,
  input  logic          degen_i,
  input  logic [RW:0]   r_i   [qmn_pkg::LANES],
  input  logic [FB:0]   q_i   [qmn_pkg::LANES],
  input  logic          neg_i [qmn_pkg::LANES],
  output logic [RW-1:0] m_o,
  output logic          degen_o,
  output logic [RW:0]   r_o   [qmn_pkg::LANES],
  output logic [FB:0]   q_o   [qmn_pkg::LANES],
  output logic          neg_o [qmn_pkg::LANES]
);
  import qmn_pkg::*;

  logic          valid_q;
  logic [RW-1:0] m_q;
  logic          degen_q;
  logic [RW:0]   r_q   [LANES];
  logic [FB:0]   q_q   [LANES];
  logic          neg_q [LANES];
  logic          ge    [LANES];
  logic [RW:0]   rest  [LANES];

  // Restoring step on each lane: subtract the magnitude where it fits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ge[l]   = (r_i[l] >= {1'b0, m_i});
      rest[l] = ge[l] ? (r_i[l] - {1'b0, m_i}) : r_i[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q     <= m_i;
      degen_q <= degen_i;
      neg_q   <= neg_i;
      for (int l = 0; l < LANES; l++) begin
        r_q[l] <= {rest[l][RW-1:0], 1'b0};
        q_q[l] <= {q_i[l][FB-1:0], ge[l]};
      end
    end
  end

  assign valid_o = valid_q;
  assign m_o     = m_q;
  assign degen_o = degen_q;
  assign r_o     = r_q;
  assign q_o     = q_q;
  assign neg_o   = neg_q;

endmodule

### rtl/quaternion_multiply_normalize_top.sv
// Top level of the normalized Hamilton quaternion product block.
//
//   Channel   Dir  tdata (lowest bits first)                    tuser
//   s_axis    in   a_w a_x a_y a_z b_w b_x b_y b_z              -
//   m_axis    out  out_w out_x out_y out_z                      degenerate
//
// One item per cycle enters and leaves while the output is not stalled; the chain of cells is the whole work.
// The chain is four front cells, then one square root cell per root bit,
// then one divide cell per quotient bit.
// Reset clears only the valid bit of every cell.
// A cell holds its item while the next one is full and stalled; empty cells close up,
// so input is taken while a result waits as long as some cell is free.
module quaternion_multiply_normalize_top #(
  parameter int unsigned FRAC_BITS      = qmn_pkg::FRAC_BITS_DEF,
  parameter int unsigned COMPONENT_BITS = qmn_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [((8*COMPONENT_BITS+7)/8)*8-1:0]       s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // out_w, out_x, out_y, out_z
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  // degenerate
  output logic                                        m_axis_tuser_o
);
  import qmn_pkg::*;

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned FB    = FRAC_BITS;
  localparam int unsigned PW    = 2 * CB + 2 - FB;
  localparam int unsigned RW    = PW + 1;
  localparam int unsigned NS    = RW;
  localparam int unsigned ND    = FB + 1;
  localparam int unsigned NT    = FRONT_STAGES + NS + ND;
  localparam int unsigned OUT_W = ((4 * CB + 7) / 8) * 8;

  logic [NT-1:0]          v;
  logic [NT-1:0]          en;
  logic signed [CB-1:0]   a [LANES];
  logic signed [CB-1:0]   b [LANES];

  logic [2*RW-1:0]        sn   [NS+1];
  logic [RW+1:0]          sr   [NS+1];
  logic [RW-1:0]          sq   [NS+1];
  logic                   sneg [NS+1][LANES];
  logic [PW-1:0]          sabs [NS+1][LANES];

  logic [RW-1:0]          dm   [ND+1];
  logic                   ddg  [ND+1];
  logic [RW:0]            dr   [ND+1][LANES];
  logic [FB:0]            dq   [ND+1][LANES];
  logic                   dneg [ND+1][LANES];

  logic signed [FB+1:0]   sv   [LANES];
  logic [CB-1:0]          res  [LANES];

  // A cell loads when it is empty or its content moves on.
  always_comb begin
    en[NT-1] = !v[NT-1] || m_axis_tready_i;
    for (int k = NT - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  // Unpack the input components.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a[i] = s_axis_tdata_i[i*CB +: CB];
      b[i] = s_axis_tdata_i[(i+LANES)*CB +: CB];
    end
  end

  qmn_front #(
    .FRAC_BITS      (FB),
    .COMPONENT_BITS (CB)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[FRONT_STAGES-1:0]),
    .valid_i (s_axis_tvalid_i),
    .valid_o (v[FRONT_STAGES-1:0]),
    .a_i     (a),
    .b_i     (b),
    .sq_o    (sn[0]),
    .neg_o   (sneg[0]),
    .abs_o   (sabs[0])
  );

  assign sr[0] = '0;
  assign sq[0] = '0;

  // Square root chain, most significant root bit first.
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    qmn_sqrt_cell #(
      .RW (RW),
      .PW (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[FRONT_STAGES+k]),
      .valid_i (v[FRONT_STAGES+k-1]),
      .valid_o (v[FRONT_STAGES+k]),
      .n_i     (sn[k]),
      .r_i     (sr[k]),
      .q_i     (sq[k]),
      .neg_i   (sneg[k]),
      .abs_i   (sabs[k]),
      .n_o     (sn[k+1]),
      .r_o     (sr[k+1]),
      .q_o     (sq[k+1]),
      .neg_o   (sneg[k+1]),
      .abs_o   (sabs[k+1])
    );
  end

  // Divide chain inputs: the root is the divisor, each magnitude the start remainder.
  assign dm[0]  = sq[NS];
  assign ddg[0] = (sq[NS] == '0);
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dr[0][l]   = (RW+1)'(sabs[NS][l]);
      dq[0][l]   = '0;
      dneg[0][l] = sneg[NS][l];
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    qmn_div_cell #(
      .RW (RW),
      .FB (FB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[FRONT_STAGES+NS+k]),
      .valid_i (v[FRONT_STAGES+NS+k-1]),
      .valid_o (v[FRONT_STAGES+NS+k]),
      .m_i     (dm[k]),
      .degen_i (ddg[k]),
      .r_i     (dr[k]),
      .q_i     (dq[k]),
      .neg_i   (dneg[k]),
      .m_o     (dm[k+1]),
      .degen_o (ddg[k+1]),
      .r_o     (dr[k+1]),
      .q_o     (dq[k+1]),
      .neg_o   (dneg[k+1])
    );
  end

  // Restore the signs; a zero product gives zero components.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sv[l]  = dneg[ND][l] ? -$signed({1'b0, dq[ND][l]}) : $signed({1'b0, dq[ND][l]});
      res[l] = ddg[ND] ? '0 : CB'(sv[l]);
    end
  end

  assign m_axis_tvalid_o = v[NT-1];
  assign m_axis_tdata_o  = OUT_W'({res[LANE_Z], res[LANE_Y], res[LANE_X], res[LANE_W]});
  assign m_axis_tuser_o  = ddg[ND];

endmodule

### rtl/qmn_checker.sv
// Port checker of the quaternion product block and its bind statement.
`include "quaternion_multiply_normalize_top_defines.svh"

module qmn_checker #(
  parameter int unsigned FRAC_BITS      = qmn_pkg::FRAC_BITS_DEF,
  parameter int unsigned COMPONENT_BITS = qmn_pkg::COMPONENT_BITS_DEF
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid_i,
  input logic                                  s_axis_tready_i,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input logic [((8*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  input logic                                  m_axis_tvalid_i,
  input logic                                  m_axis_tready_i,
  // out_w, out_x, out_y, out_z
  input logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata_i,
  // degenerate
  input logic                                  m_axis_tuser_i
);
  import qmn_pkg::*;

  // A stalled result stays offered and unchanged.
  `QMN_ASSERT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i), "result changed while stalled")

  // A zero product delivers zero components.
  `QMN_ASSERT(a_degen_zero, m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i == '0, "degenerate item with nonzero data")

  // With the output empty every cell can move on, so input is taken.
  `QMN_ASSERT(a_ready_empty, !m_axis_tvalid_i |-> s_axis_tready_i, "input stalled with empty output")

  // Reset empties the chain at once.
  `QMN_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid_i, "result offered during reset")

endmodule

bind quaternion_multiply_normalize_top qmn_checker #(
  .FRAC_BITS      (FRAC_BITS),
  .COMPONENT_BITS (COMPONENT_BITS)
) u_qmn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
